// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers on clk_i and rst_ni, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge out of reset.
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Condition must never be true out of reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ----- hw/rtl/rcb_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// RGB 9x9 convolution package
// Types, register codes and kernel coefficient tables shared by the block.
// ---------------------------------------------------------------------------
package rcb_pkg;

  // Register file layout.
  localparam int unsigned SZ_W       = 11;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER = 2'd2;
  localparam logic [SZ_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [SZ_W-1:0] HEIGHT_RST = 11'd480;

  // Defaults for the top-level parameters.
  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_HEIGHT = 1024;

  // Kernel geometry.
  localparam int unsigned KSIZE  = 9;
  localparam int unsigned HALF_K = KSIZE / 2;
  localparam int unsigned QN     = HALF_K + 1;
  localparam int unsigned TAPS   = KSIZE * KSIZE;
  localparam int unsigned HIST_ROWS_W = 4;

  // Datapath widths.
  localparam int unsigned COEF_W = 10;
  localparam int unsigned ACC_W  = 24;
  localparam int unsigned WGT_W  = 16;
  localparam int unsigned PIX_W  = 24;

  localparam logic signed [WGT_W-1:0] BLUR_WEIGHT  = 16'sd9993;
  localparam logic signed [WGT_W-1:0] SHARP_WEIGHT = -16'sd128;

  typedef logic [7:0] chan_t;

  typedef struct packed {
    logic  kind;
    chan_t in_red;
    chan_t in_green;
    chan_t in_blue;
  } in_item_t;

  typedef struct packed {
    chan_t out_red;
    chan_t out_green;
    chan_t out_blue;
    logic  frame_end;
  } out_item_t;

  // One window tap as it travels along the cell chain.
  typedef struct packed {
    logic [PIX_W-1:0]         pix;
    logic                     ok;
    logic signed [COEF_W-1:0] coef;
  } tap_t;

  // Upper-left quadrant of each symmetric kernel.
  localparam logic signed [COEF_W-1:0] BLUR_Q [QN*QN] = '{
    10'sd8,  10'sd18,  10'sd34,  10'sd50,  10'sd56,
    10'sd18, 10'sd44,  10'sd82,  10'sd119, 10'sd135,
    10'sd34, 10'sd82,  10'sd153, 10'sd223, 10'sd253,
    10'sd50, 10'sd119, 10'sd223, 10'sd325, 10'sd368,
    10'sd56, 10'sd135, 10'sd253, 10'sd368, 10'sd417
  };

  localparam logic signed [COEF_W-1:0] SHARP_Q [QN*QN] = '{
    10'sd0, 10'sd1, 10'sd1, 10'sd2,   10'sd2,
    10'sd1, 10'sd2, 10'sd4, 10'sd5,   10'sd5,
    10'sd1, 10'sd4, 10'sd5, 10'sd3,   10'sd0,
    10'sd2, 10'sd5, 10'sd3, -10'sd20, -10'sd36,
    10'sd2, 10'sd5, 10'sd0, -10'sd36, -10'sd88
  };

  // Coefficient at kernel row k, column l, folded onto the quadrant.
  function automatic logic signed [COEF_W-1:0] kernel_coef(input logic       sel,
                                                           input logic [3:0] k,
                                                           input logic [3:0] l);
    logic [2:0] fk;
    logic [2:0] fl;
    logic [4:0] idx;
    fk  = (k > 4'(HALF_K)) ? 3'(4'(KSIZE - 1) - k) : 3'(k);
    fl  = (l > 4'(HALF_K)) ? 3'(4'(KSIZE - 1) - l) : 3'(l);
    idx = 5'(fk) * 5'(QN) + 5'(fl);
    return sel ? SHARP_Q[idx] : BLUR_Q[idx];
  endfunction

endpackage

// ----- hw/rtl/rcb_cell.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Window cell
// One tap of the 9x9 window; passes its tap to the next cell on each shift.
// ---------------------------------------------------------------------------
module rcb_cell
  import rcb_pkg::*;
(
  input  logic clk_i,
  input  logic shift_i,
  input  tap_t tap_i,
  output tap_t tap_o
);

  tap_t tap_q;

  // Taps outside the image hold a zero pixel.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      tap_q.pix  <= tap_i.ok ? tap_i.pix : '0;
      tap_q.ok   <= tap_i.ok;
      tap_q.coef <= tap_i.coef;
    end
  end

  assign tap_o = tap_q;

endmodule

// ----- hw/rtl/rcb_div.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Normalizing divider
// Bit-serial signed division truncating toward zero, then clamp to 0..255.
// ---------------------------------------------------------------------------
module rcb_div
  import rcb_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [ACC_W-1:0] dividend_i,
  input  logic signed [WGT_W-1:0] divisor_i,
  output logic                    done_o,
  output chan_t                   result_o
);

  localparam int unsigned CNT_W = $clog2(ACC_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ACC_W - 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [ACC_W-1:0] quo_q;
  logic [WGT_W-1:0] rem_q;
  logic [WGT_W-1:0] den_q;
  logic             neg_q;

  logic [ACC_W-1:0] num_mag;
  logic [WGT_W-1:0] den_mag;
  logic [WGT_W:0]   trial;
  logic             ge;
  logic [WGT_W-1:0] rem_d;

  assign num_mag = dividend_i[ACC_W-1] ? ACC_W'(-dividend_i) : ACC_W'(dividend_i);
  assign den_mag = divisor_i[WGT_W-1] ? WGT_W'(-divisor_i) : WGT_W'(divisor_i);

  // One restoring step per cycle.
  assign trial = {rem_q, quo_q[ACC_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign rem_d = ge ? WGT_W'(trial - {1'b0, den_q}) : WGT_W'(trial);

  // Sequencing; a zero divisor passes the sum through unchanged.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= start_i ? (divisor_i == '0) : (busy_q && (cnt_q == CNT_LAST));
      if (start_i) begin
        busy_q <= (divisor_i != '0);
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Operand and quotient registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_mag;
      den_q <= den_mag;
      rem_q <= '0;
      neg_q <= dividend_i[ACC_W-1] ^ ((divisor_i != '0) && divisor_i[WGT_W-1]);
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[ACC_W-2:0], ge};
    end
  end

  // A negative quotient clamps to zero, a large one to full scale.
  always_comb begin
    if (neg_q && (quo_q != '0)) begin
      result_o = '0;
    end else if (quo_q > ACC_W'(255)) begin
      result_o = 8'hFF;
    end else begin
      result_o = quo_q[7:0];
    end
  end

  assign done_o = done_q;

endmodule

// ----- hw/rtl/rgb_conv9x9_border_renorm.sv -----
`timescale 1ns / 1ps
// Sequence: an item with no result frees the input after the check; one with a result goes
// through check, memory reads of all 81 taps, fill, accumulate shifts over all 81 taps, the
// dividers' 24 steps (skipped with a zero weight), result and idle, plus any wait for a full output register.
// Throughput is set by the single line memory read port and the 81-cell window chain.
// Reset: asynchronous active low; size registers return to 640x480, blur is selected,
// all position counters clear; the line memory is not cleared.
// ---------------------------------------------------------------------------
// RGB 9x9 border-renormalized convolution
// Line memory, 81-cell window chain, accumulator and three normalizing dividers.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rgb_conv9x9_border_renorm
  import rcb_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_data_o
);

  localparam int unsigned COL_AW    = $clog2(MAX_WIDTH);
  localparam int unsigned MEM_AW    = HIST_ROWS_W + COL_AW;
  localparam int unsigned MEM_DEPTH = 1 << MEM_AW;
  localparam int unsigned RC_W      = SZ_W + 2;
  localparam int unsigned TAP_CW    = $clog2(TAPS);
  localparam int unsigned SZ_MAX    = (1 << SZ_W) - 1;
  localparam logic [SZ_W-1:0] W_LIMIT = SZ_W'((MAX_WIDTH > SZ_MAX) ? SZ_MAX : MAX_WIDTH);
  localparam logic [SZ_W-1:0] H_LIMIT = SZ_W'((MAX_HEIGHT > SZ_MAX) ? SZ_MAX : MAX_HEIGHT);
  localparam logic [TAP_CW-1:0] TAP_LAST = TAP_CW'(TAPS - 1);
  localparam logic [3:0] K_LAST = 4'(KSIZE - 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHECK, ST_LOAD, ST_FILL, ST_MAC, ST_DIV, ST_RESULT
  } state_e;

  state_e                   state_q;
  logic [SZ_W-1:0]          width_q, height_q;
  logic                     filt_q, sel_q, last_q;
  logic [SZ_W-1:0]          in_row_q, in_col_q, out_row_q, out_col_q;
  logic [3:0]               k_q, l_q;
  logic [TAP_CW-1:0]        mac_cnt_q;
  logic signed [ACC_W-1:0]  acc_r_q, acc_g_q, acc_b_q;
  logic signed [WGT_W-1:0]  wgt_q;
  logic                     div_start_q;
  logic                     rd_vld_q, rd_ok_q;
  logic signed [COEF_W-1:0] rd_coef_q;
  logic [PIX_W-1:0]         rd_data_q;
  logic                     out_valid_q;
  out_item_t                out_data_q;

  logic [PIX_W-1:0] line_mem [MEM_DEPTH];

  // ---- Input side ----
  logic             in_acc, pix_we, in_col_wrap;
  logic [MEM_AW-1:0] wr_addr;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign pix_we      = in_acc && !in_data_i.kind && (in_row_q < height_q);
  assign in_col_wrap = ({1'b0, in_col_q} + 1'b1) >= {1'b0, width_q};
  assign wr_addr     = {in_row_q[HIST_ROWS_W-1:0], COL_AW'(in_col_q)};

  // ---- Emission test: has the input reached the clamped target? ----
  logic [SZ_W:0]   tr_s, tc_s;
  logic [SZ_W-1:0] h_m1, w_m1, tr, tc;
  logic            emit;

  assign h_m1 = height_q - 1'b1;
  assign w_m1 = width_q - 1'b1;
  assign tr_s = {1'b0, out_row_q} + (SZ_W+1)'(HALF_K);
  assign tc_s = {1'b0, out_col_q} + (SZ_W+1)'(HALF_K);
  assign tr   = (tr_s > {1'b0, h_m1}) ? h_m1 : tr_s[SZ_W-1:0];
  assign tc   = (tc_s > {1'b0, w_m1}) ? w_m1 : tc_s[SZ_W-1:0];
  assign emit = (out_row_q < height_q) &&
                ((in_row_q > tr) || ((in_row_q == tr) && (in_col_q > tc)));

  // ---- Tap address and border test ----
  logic [RC_W-1:0]   tap_r, tap_c;
  logic              tap_ok;
  logic [MEM_AW-1:0] rd_addr;

  assign tap_r  = RC_W'(out_row_q) + RC_W'(k_q) - RC_W'(HALF_K);
  assign tap_c  = RC_W'(out_col_q) + RC_W'(l_q) - RC_W'(HALF_K);
  assign tap_ok = !tap_r[RC_W-1] && (tap_r < RC_W'(height_q)) &&
                  !tap_c[RC_W-1] && (tap_c < RC_W'(width_q));
  assign rd_addr = {tap_r[HIST_ROWS_W-1:0], COL_AW'(tap_c)};

  // Line memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (pix_we) begin
      line_mem[wr_addr] <= {in_data_i.in_blue, in_data_i.in_green, in_data_i.in_red};
    end
    if (state_q == ST_LOAD) begin
      rd_data_q <= line_mem[rd_addr];
      rd_ok_q   <= tap_ok;
      rd_coef_q <= kernel_coef(sel_q, k_q, l_q);
    end
  end

  // ---- Window cell chain ----
  tap_t chain [TAPS+1];
  logic shift;
  tap_t tail;

  assign shift = rd_vld_q || (state_q == ST_MAC);
  assign tail  = chain[TAPS];

  // Fill from memory, then rotate the tail back to the head while summing.
  always_comb begin
    if (state_q == ST_MAC) begin
      chain[0] = tail;
    end else begin
      chain[0].pix  = rd_data_q;
      chain[0].ok   = rd_ok_q;
      chain[0].coef = rd_coef_q;
    end
  end

  for (genvar i = 0; i < TAPS; i++) begin : g_cell
    rcb_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift),
      .tap_i   (chain[i]),
      .tap_o   (chain[i+1])
    );
  end

  // ---- Multiply-accumulate on the chain tail ----
  logic signed [COEF_W+8:0] prod_r, prod_g, prod_b;

  assign prod_r = tail.coef * $signed({1'b0, tail.pix[7:0]});
  assign prod_g = tail.coef * $signed({1'b0, tail.pix[15:8]});
  assign prod_b = tail.coef * $signed({1'b0, tail.pix[23:16]});

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CHECK) begin
      acc_r_q <= '0;
      acc_g_q <= '0;
      acc_b_q <= '0;
      wgt_q   <= filt_q ? SHARP_WEIGHT : BLUR_WEIGHT;
    end else if (state_q == ST_MAC) begin
      acc_r_q <= acc_r_q + ACC_W'(prod_r);
      acc_g_q <= acc_g_q + ACC_W'(prod_g);
      acc_b_q <= acc_b_q + ACC_W'(prod_b);
      if (!tail.ok) begin
        wgt_q <= wgt_q - WGT_W'(tail.coef);
      end
    end
  end

  // ---- Normalizing dividers, one per channel ----
  logic  done_r, done_g, done_b;
  chan_t res_r, res_g, res_b;

  rcb_div u_div_r (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start_q), .dividend_i(acc_r_q),
    .divisor_i(wgt_q), .done_o(done_r), .result_o(res_r)
  );
  rcb_div u_div_g (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start_q), .dividend_i(acc_g_q),
    .divisor_i(wgt_q), .done_o(done_g), .result_o(res_g)
  );
  rcb_div u_div_b (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start_q), .dividend_i(acc_b_q),
    .divisor_i(wgt_q), .done_o(done_b), .result_o(res_b)
  );

  logic div_done;
  assign div_done = done_r && done_g && done_b;

  // ---- Control sequencer, counters, registers and output stage ----
  logic [SZ_W-1:0] cfg_size;
  logic            out_load;

  assign out_load = (state_q == ST_RESULT) && (!out_valid_q || out_ready_i);

  always_comb begin
    cfg_size = cfg_data_i;
    if (cfg_data_i == '0) begin
      cfg_size = SZ_W'(1);
    end else if ((cfg_idx_i == REG_WIDTH) && (cfg_data_i > W_LIMIT)) begin
      cfg_size = W_LIMIT;
    end else if ((cfg_idx_i == REG_HEIGHT) && (cfg_data_i > H_LIMIT)) begin
      cfg_size = H_LIMIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      width_q     <= WIDTH_RST;
      height_q    <= HEIGHT_RST;
      filt_q      <= 1'b0;
      sel_q       <= 1'b0;
      last_q      <= 1'b0;
      in_row_q    <= '0;
      in_col_q    <= '0;
      out_row_q   <= '0;
      out_col_q   <= '0;
      k_q         <= '0;
      l_q         <= '0;
      mac_cnt_q   <= '0;
      div_start_q <= 1'b0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      div_start_q <= (state_q == ST_MAC) && (mac_cnt_q == TAP_LAST);
      rd_vld_q    <= (state_q == ST_LOAD);
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (pix_we) begin
              if (in_col_wrap) begin
                in_col_q <= '0;
                in_row_q <= in_row_q + 1'b1;
              end else begin
                in_col_q <= in_col_q + 1'b1;
              end
            end
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (emit) begin
            sel_q   <= filt_q;
            last_q  <= (out_row_q == h_m1) && (out_col_q == w_m1);
            k_q     <= '0;
            l_q     <= '0;
            state_q <= ST_LOAD;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_LOAD: begin
          if (l_q == K_LAST) begin
            l_q <= '0;
            k_q <= k_q + 1'b1;
            if (k_q == K_LAST) begin
              state_q <= ST_FILL;
            end
          end else begin
            l_q <= l_q + 1'b1;
          end
        end
        ST_FILL: begin
          mac_cnt_q <= '0;
          state_q   <= ST_MAC;
        end
        ST_MAC: begin
          mac_cnt_q <= mac_cnt_q + 1'b1;
          if (mac_cnt_q == TAP_LAST) begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (out_load) begin
            out_data_q  <= '{out_red: res_r, out_green: res_g, out_blue: res_b,
                             frame_end: last_q};
            if (last_q) begin
              in_row_q  <= '0;
              in_col_q  <= '0;
              out_row_q <= '0;
              out_col_q <= '0;
            end else if (({1'b0, out_col_q} + 1'b1) >= {1'b0, width_q}) begin
              out_col_q <= '0;
              out_row_q <= out_row_q + 1'b1;
            end else begin
              out_col_q <= out_col_q + 1'b1;
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
      // Configuration writes; a size change restarts the frame.
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_WIDTH: begin
            width_q   <= cfg_size;
            in_row_q  <= '0;
            in_col_q  <= '0;
            out_row_q <= '0;
            out_col_q <= '0;
          end
          REG_HEIGHT: begin
            height_q  <= cfg_size;
            in_row_q  <= '0;
            in_col_q  <= '0;
            out_row_q <= '0;
            out_col_q <= '0;
          end
          REG_FILTER: begin
            filt_q <= cfg_data_i[0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // ---- Assertions ----
  `ASSERT_PROP(a_out_row_in_frame, out_row_q < height_q, "output row beyond frame height")
  `ASSERT_PROP(a_cols_in_row, (in_col_q < width_q) && (out_col_q < width_q), "column beyond width")
  `ASSERT_NEVER(a_div_done_stray, div_done && (state_q != ST_DIV), "divider done outside DIV")
  `ASSERT_PROP(a_emit_behind_input, (state_q == ST_RESULT) |-> ((in_row_q > out_row_q) || ((in_row_q == out_row_q) && (in_col_q > out_col_q))), "result ahead of input")

endmodule

// ----- tb/sv/rgb_conv9x9_border_renorm_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// RGB 9x9 border-renormalized convolution testbench
// Drives pixel and flush transactions through several frame sizes and both
// kernels, predicts every output pixel in a behavioral copy of the filter, and
// compares each output transaction field by field, in order.
// ---------------------------------------------------------------------------
module rgb_conv9x9_border_renorm_test;
  import rcb_pkg::*;

  localparam int unsigned MAX_DIM      = 1024;
  localparam int unsigned HIST_DEPTH   = 16;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned RAND_ITEMS   = 800;
  localparam int unsigned QUIET_AFTER  = 650;
  localparam int unsigned LONG_HOLD    = 600;
  localparam logic        KIND_PIXEL   = 1'b0;
  localparam logic        KIND_FLUSH   = 1'b1;

  // One row of the directed stimulus table.
  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    in_item_t              item;
    bit                    typed;
    out_item_t             res;
  } dir_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  in_item_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  out_item_t             out_data_o;

  // Filter state mirrored from the block.
  int          frame_w;
  int          frame_h;
  logic        use_sharpen;
  logic [23:0] row_hist [HIST_DEPTH][MAX_DIM];
  int          in_r, in_c, out_r, out_c;

  out_item_t   pixel_q [$];
  dir_row_t    dir_tab [$];
  int          fails;
  int          rx_count;
  int          rand_sent;
  bit          quiet;
  int          idle_cycles;

  rgb_conv9x9_border_renorm i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Out-of-range sizes fold into 1..MAX_DIM.
  function automatic int fold_size(input logic [CFG_DATA_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  function automatic int tap_coef(input logic sel, input int k, input int l);
    int fk;
    int fl;
    fk = (k > int'(HALF_K)) ? int'(KSIZE) - 1 - k : k;
    fl = (l > int'(HALF_K)) ? int'(KSIZE) - 1 - l : l;
    return sel ? int'(SHARP_Q[fk * QN + fl]) : int'(BLUR_Q[fk * QN + fl]);
  endfunction

  // Divide by the remaining weight (truncating) unless it is zero, then clamp.
  function automatic chan_t renorm(input int sum, input int wgt);
    int v;
    v = (wgt != 0) ? sum / wgt : sum;
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return chan_t'(v);
  endfunction

  function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_WIDTH: begin
        frame_w = fold_size(data);
        in_r = 0; in_c = 0; out_r = 0; out_c = 0;
      end
      REG_HEIGHT: begin
        frame_h = fold_size(data);
        in_r = 0; in_c = 0; out_r = 0; out_c = 0;
      end
      REG_FILTER: use_sharpen = data[0];
      default: ;
    endcase
  endfunction

  // Store the pixel if any, then emit the next output if its window is complete.
  function automatic bit filter_pixel(input in_item_t it, output out_item_t res);
    int   tr, tc, r, c, cf, sr, sg, sb, wgt;
    logic [23:0] p;
    bit   last;
    res = '0;
    if (it.kind == KIND_PIXEL && in_r < frame_h) begin
      row_hist[in_r % HIST_DEPTH][in_c] = {it.in_blue, it.in_green, it.in_red};
      in_c++;
      if (in_c >= frame_w) begin
        in_c = 0;
        in_r++;
      end
    end
    if (out_r >= frame_h) return 1'b0;
    tr = (out_r + int'(HALF_K) > frame_h - 1) ? frame_h - 1 : out_r + int'(HALF_K);
    tc = (out_c + int'(HALF_K) > frame_w - 1) ? frame_w - 1 : out_c + int'(HALF_K);
    if (in_r * frame_w + in_c <= tr * frame_w + tc) return 1'b0;
    sr = 0; sg = 0; sb = 0;
    wgt = use_sharpen ? int'(SHARP_WEIGHT) : int'(BLUR_WEIGHT);
    for (int k = 0; k < int'(KSIZE); k++) begin
      for (int l = 0; l < int'(KSIZE); l++) begin
        r  = out_r - int'(HALF_K) + k;
        c  = out_c - int'(HALF_K) + l;
        cf = tap_coef(use_sharpen, k, l);
        if (r >= 0 && c >= 0 && r < frame_h && c < frame_w) begin
          p  = row_hist[r % HIST_DEPTH][c];
          sr += cf * int'(p[7:0]);
          sg += cf * int'(p[15:8]);
          sb += cf * int'(p[23:16]);
        end else begin
          wgt -= cf;
        end
      end
    end
    last = (out_r == frame_h - 1) && (out_c == frame_w - 1);
    res.out_red   = renorm(sr, wgt);
    res.out_green = renorm(sg, wgt);
    res.out_blue  = renorm(sb, wgt);
    res.frame_end = last;
    if (last) begin
      in_r = 0; in_c = 0; out_r = 0; out_c = 0;
    end else begin
      out_c++;
      if (out_c >= frame_w) begin
        out_c = 0;
        out_r++;
      end
    end
    return 1'b1;
  endfunction

  function automatic bit at_frame_start();
    return in_r == 0 && in_c == 0 && out_r == 0 && out_c == 0;
  endfunction

  function automatic in_item_t make_item(input logic kind);
    in_item_t it;
    it.kind     = kind;
    it.in_red   = chan_t'($urandom);
    it.in_green = chan_t'($urandom);
    it.in_blue  = chan_t'($urandom);
    return it;
  endfunction

  function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
    dir_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.data   = data;
    dir_tab.push_back(row);
  endfunction

  function automatic void add_item(input logic kind, input chan_t r, input chan_t g,
                                   input chan_t b, input bit typed, input out_item_t res);
    dir_row_t row;
    row = '{default: '0};
    row.item  = '{kind: kind, in_red: r, in_green: g, in_blue: b};
    row.typed = typed;
    row.res   = res;
    dir_tab.push_back(row);
  endfunction

  // Offer one transaction and hold it until accepted, then predict its output.
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t typed_res);
    out_item_t res;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (filter_pixel(it, res)) begin
      if (typed && res !== typed_res) begin
        $error("directed expectation %h differs from prediction %h", typed_res, res);
        fails++;
      end
      pixel_q.push_back(typed ? typed_res : res);
    end
  endtask

  // Hold input until every expected output is back and the block has settled.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    apply_cfg(idx, data);
  endtask

  // Directed table: single-pixel frames give outputs equal to the input, then
  // out-of-range sizes and a frame abandoned by a size write.
  initial begin
    add_cfg(REG_WIDTH, 11'd1);
    add_cfg(REG_HEIGHT, 11'd1);
    add_cfg(REG_FILTER, 11'd0);
    add_item(KIND_PIXEL, 8'd255, 8'd0, 8'd128, 1'b1, '{8'd255, 8'd0, 8'd128, 1'b1});
    add_item(KIND_FLUSH, 8'd0, 8'd0, 8'd0, 1'b0, '0);
    add_item(KIND_PIXEL, 8'd0, 8'd255, 8'd1, 1'b1, '{8'd0, 8'd255, 8'd1, 1'b1});
    add_cfg(REG_FILTER, 11'd1);
    add_item(KIND_PIXEL, 8'd255, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd255, 8'd255, 1'b1});
    add_item(KIND_PIXEL, 8'd0, 8'd0, 8'd0, 1'b1, '{8'd0, 8'd0, 8'd0, 1'b1});
    add_item(KIND_PIXEL, 8'd1, 8'd2, 8'd3, 1'b1, '{8'd1, 8'd2, 8'd3, 1'b1});
    add_cfg(REG_WIDTH, 11'd0);
    add_cfg(REG_HEIGHT, 11'd2047);
    for (int i = 0; i < 3; i++) add_item(KIND_PIXEL, 8'd17, 8'd170, 8'd85, 1'b0, '0);
    add_cfg(REG_WIDTH, 11'd2047);
    add_cfg(REG_HEIGHT, 11'd0);
    for (int i = 0; i < 6; i++) add_item(KIND_PIXEL, chan_t'(40 * i), 8'd200, 8'd7, 1'b0, '0);
    add_item(KIND_FLUSH, 8'd255, 8'd255, 8'd255, 1'b0, '0);
    add_item(KIND_FLUSH, 8'd0, 8'd0, 8'd0, 1'b0, '0);
  end

  // Stimulus.
  initial begin
    int w, h, nframes, npix;
    bit broken;
    fails = 0; rand_sent = 0; quiet = 0;
    frame_w = int'(WIDTH_RST); frame_h = int'(HEIGHT_RST); use_sharpen = 1'b0;
    in_r = 0; in_c = 0; out_r = 0; out_c = 0;
    rst_ni = 1'b0; cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_data_i = '0;
    in_valid_i = 1'b0; in_data_i = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        wait_drained();
        write_reg(dir_tab[i].idx, dir_tab[i].data);
      end else begin
        send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].res);
      end
    end

    // Random phases: mostly complete frames with random content, some noise
    // flushes, stray pixels after the frame, and broken frames.
    while (rand_sent < RAND_ITEMS) begin
      wait_drained();
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      h = $urandom_range(1, 10);
      if ($urandom_range(0, 1)) begin
        write_reg(REG_HEIGHT, CFG_DATA_W'(h));
        write_reg(REG_WIDTH, CFG_DATA_W'(w));
      end else begin
        write_reg(REG_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_HEIGHT, CFG_DATA_W'(h));
      end
      write_reg(REG_FILTER, CFG_DATA_W'($urandom_range(0, 1)));
      nframes = $urandom_range(1, 3);
      for (int f = 0; f < nframes; f++) begin
        broken = ($urandom_range(0, 19) == 0) && (w * h > 1);
        npix   = broken ? $urandom_range(1, w * h - 1) : w * h;
        for (int i = 0; i < npix; i++) begin
          if ($urandom_range(0, 9) == 0) begin
            send_item(make_item(KIND_FLUSH), 1'b0, '0);
            rand_sent++;
          end
          send_item(make_item(KIND_PIXEL), 1'b0, '0);
          rand_sent++;
          quiet = rand_sent > QUIET_AFTER;
        end
        if (broken) break;
        // A pixel after the whole frame but before its last output is dropped.
        if (!at_frame_start() && $urandom_range(0, 3) == 0) begin
          send_item(make_item(KIND_PIXEL), 1'b0, '0);
          rand_sent++;
        end
        while (!at_frame_start()) begin
          send_item(make_item(KIND_FLUSH), 1'b0, '0);
          rand_sent++;
        end
        // Flushes with nothing left to drain.
        if ($urandom_range(0, 4) == 0) begin
          send_item(make_item(KIND_FLUSH), 1'b0, '0);
          rand_sent++;
        end
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fails == 0 && pixel_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Output ready: random stalls, one long hold to back up the input, none at the end.
  initial begin
    bit held;
    held = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held && rx_count >= 40) begin
        held = 1;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (quiet || $urandom_range(0, 3) != 0) begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end
    end
  end

  // Output checking and watchdog.
  initial rx_count = 0;
  initial idle_cycles = 0;
  always @(posedge clk_i) begin
    out_item_t exp_px;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        rx_count++;
        if (pixel_q.size() == 0) begin
          $error("output transaction %h with no pixel expected", out_data_o);
          fails++;
        end else begin
          exp_px = pixel_q.pop_front();
          if (out_data_o.out_red !== exp_px.out_red) begin
            $error("out_red: expected %0d, actual %0d", exp_px.out_red, out_data_o.out_red);
            fails++;
          end
          if (out_data_o.out_green !== exp_px.out_green) begin
            $error("out_green: expected %0d, actual %0d",
                   exp_px.out_green, out_data_o.out_green);
            fails++;
          end
          if (out_data_o.out_blue !== exp_px.out_blue) begin
            $error("out_blue: expected %0d, actual %0d", exp_px.out_blue, out_data_o.out_blue);
            fails++;
          end
          if (out_data_o.frame_end !== exp_px.frame_end) begin
            $error("frame_end: expected %0d, actual %0d",
                   exp_px.frame_end, out_data_o.frame_end);
            fails++;
          end
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

endmodule
